[rtl/wbps_pkg.sv]
// ----------------------------------------------------------------------------
// wbps_pkg: shared types and constants for the wildcard byte pattern scan
// Register map codes, configuration bundle and field widths.
// ----------------------------------------------------------------------------
package wbps_pkg;

  // Field widths fixed by the register map and the stream payload
  localparam int PAT_CFG_BYTES   = 16;   // pattern bytes held in configuration
  localparam int WILD_W          = 16;
  localparam int PLEN_W          = 5;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_ADDR_W      = 5;    // four registers at 8-byte spacing
  localparam int RESULT_OFFSET_W = 32;

  typedef logic [7:0] byte_t;

  // Register indexes (paddr[4:3])
  typedef enum logic [1:0] {
    REG_PAT_LO    = 2'd0,
    REG_PAT_HI    = 2'd1,
    REG_WILD_MASK = 2'd2,
    REG_PAT_LEN   = 2'd3
  } cfg_reg_t;

  // Pattern configuration as seen by the compare logic
  typedef struct packed {
    logic [CFG_DATA_W-1:0] pat_hi;
    logic [CFG_DATA_W-1:0] pat_lo;
    logic [WILD_W-1:0]     wild;
  } pat_cfg_t;

endpackage

[rtl/wbps_window_match.sv]
// ----------------------------------------------------------------------------
// wbps_window_match: parallel wildcard compare of the byte window
// Checks the newest len window bytes against the pattern in one pass.
// ----------------------------------------------------------------------------
module wbps_window_match import wbps_pkg::*; #(
  parameter int MAX_PATTERN_BYTES = 16
) (
  input  byte_t                                  win [MAX_PATTERN_BYTES],
  input  pat_cfg_t                               cfg,
  input  logic [$clog2(MAX_PATTERN_BYTES+1)-1:0] len,
  output logic                                   hit
);

  localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

  byte_t                        pat  [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] wild;
  logic [MAX_PATTERN_BYTES-1:0] eq;

  // Pattern bytes past the configured sixteen are zero and never wild
  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_pat
    if (k < PAT_CFG_BYTES) begin : g_cfg
      assign pat[k]  = byte_t'({cfg.pat_hi, cfg.pat_lo} >> (8 * k));
      assign wild[k] = cfg.wild[k];
    end else begin : g_zero
      assign pat[k]  = '0;
      assign wild[k] = 1'b0;
    end
  end

  // Window entry j (0 = newest) lines up with pattern byte len-1-j
  always_comb begin
    logic [LEN_W-1:0] diff;
    logic [IDX_W-1:0] k;
    logic             en;
    for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
      en    = LEN_W'(j) < len;
      diff  = len - LEN_W'(1) - LEN_W'(j);
      k     = diff[IDX_W-1:0];
      eq[j] = en ? (wild[k] || (win[j] == pat[k])) : 1'b1;
    end
  end

  assign hit = &eq;

endmodule

[rtl/wildcard_byte_pattern_scan.sv]
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan: first-match byte pattern search over a stream
// Window, byte count, match flag, result register and APB register file.
// ----------------------------------------------------------------------------
// Takes one image byte per beat, every cycle unless stalled, with no gaps
// needed between scans. The whole pattern (up to MAX_PATTERN_BYTES, wildcards
// per byte) is compared against the byte window in the same cycle the byte is
// taken, so a result appears on the output register in the cycle after the
// byte that decides it. Each scan (ended by tlast) gives exactly one result
// beat: tuser=1 with the offset of the match start, or tuser=0 and offset 0 on
// the last byte. Bytes after a match are dropped until tlast. A waiting result
// holds the input only when it is not taken in the same cycle. The user must
// write registers over APB only while no scan is in flight (not enforced).
module wildcard_byte_pattern_scan import wbps_pkg::*; #(
  parameter int MAX_PATTERN_BYTES = 16,
  parameter int OFFSET_BITS       = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // byte stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,     // [7:0] data_byte
  input  logic                       in_tlast,     // last_byte
  // result stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [RESULT_OFFSET_W-1:0] out_tdata,    // [31:0] match_offset
  output logic                       out_tuser,    // [0] found
  // register port
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);

  // Registers
  logic [CFG_DATA_W-1:0]  pat_lo_r, pat_hi_r;
  logic [WILD_W-1:0]      wild_r;
  logic [PLEN_W-1:0]      plen_r;
  byte_t                  win_r   [MAX_PATTERN_BYTES];
  byte_t                  win_nxt [MAX_PATTERN_BYTES];
  logic [OFFSET_BITS-1:0] seen_r, seen_nxt;
  logic                   found_r, found_nxt;
  logic                   out_valid_r;
  logic                   out_found_r;
  logic [RESULT_OFFSET_W-1:0] out_offset_r;

  cfg_reg_t               reg_sel;
  logic                   cfg_wr;
  logic [LEN_W-1:0]       len_act;
  pat_cfg_t               pcfg;
  logic                   hit_win;
  logic                   hit;
  logic                   produce;
  logic                   acc;
  logic [OFFSET_BITS-1:0] seen_inc;
  logic [OFFSET_BITS-1:0] offset_full;

  // APB decode: register index from paddr[4:3]
  assign reg_sel    = cfg_reg_t'(cfg_paddr[4:3]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      wild_r   <= '0;
      plen_r   <= PLEN_W'(1);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_PAT_LO:    pat_lo_r <= cfg_pwdata;
        REG_PAT_HI:    pat_hi_r <= cfg_pwdata;
        REG_WILD_MASK: wild_r   <= cfg_pwdata[WILD_W-1:0];
        REG_PAT_LEN:   plen_r   <= cfg_pwdata[PLEN_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PAT_LO:    cfg_prdata = pat_lo_r;
      REG_PAT_HI:    cfg_prdata = pat_hi_r;
      REG_WILD_MASK: cfg_prdata = CFG_DATA_W'(wild_r);
      REG_PAT_LEN:   cfg_prdata = CFG_DATA_W'(plen_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // Effective length: zero means one, clamp to the window depth
  always_comb begin
    if (plen_r == '0)
      len_act = LEN_W'(1);
    else if (int'(plen_r) > MAX_PATTERN_BYTES)
      len_act = LEN_W'(MAX_PATTERN_BYTES);
    else
      len_act = LEN_W'(plen_r);
  end

  assign pcfg = '{pat_hi: pat_hi_r, pat_lo: pat_lo_r, wild: wild_r};

  // Beat accept: room when the result register is empty or draining
  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;

  // Window after taking this byte, entry 0 newest
  always_comb begin
    win_nxt[0] = in_tdata;
    for (int j = 1; j < MAX_PATTERN_BYTES; j++)
      win_nxt[j] = win_r[j-1];
  end

  // Saturating byte count
  assign seen_inc = (seen_r == '1) ? seen_r : seen_r + OFFSET_BITS'(1);

  wbps_window_match #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
  ) u_match (
    .win (win_nxt),
    .cfg (pcfg),
    .len (len_act),
    .hit (hit_win)
  );

  assign hit         = !found_r && hit_win && (seen_inc >= OFFSET_BITS'(len_act));
  assign offset_full = seen_inc - OFFSET_BITS'(len_act);
  assign produce     = acc && !found_r && (hit || in_tlast);

  // Scan state update
  always_comb begin
    seen_nxt  = seen_r;
    found_nxt = found_r;
    if (acc) begin
      if (in_tlast) begin
        seen_nxt  = '0;
        found_nxt = 1'b0;
      end else if (!found_r) begin
        seen_nxt  = seen_inc;
        found_nxt = hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      found_r <= 1'b0;
      for (int j = 0; j < MAX_PATTERN_BYTES; j++)
        win_r[j] <= '0;
    end else begin
      seen_r  <= seen_nxt;
      found_r <= found_nxt;
      if (acc && in_tlast) begin
        for (int j = 0; j < MAX_PATTERN_BYTES; j++)
          win_r[j] <= '0;
      end else if (acc && !found_r) begin
        win_r <= win_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (produce)
      out_valid_r <= 1'b1;
    else if (out_tready)
      out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out_found_r  <= hit;
      out_offset_r <= hit ? RESULT_OFFSET_W'(offset_full) : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = out_offset_r;

  // Checks
  a_scan_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_tlast |=> (seen_r == '0) && !found_r)
    else $error("scan state not cleared after last byte");

  a_miss_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_offset_r == '0)
    else $error("not-found result carries a non-zero offset");

  a_found_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    acc && found_r && !(out_valid_r && !out_tready) |=> !out_valid_r)
    else $error("second result within one scan");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && (seen_r == '0) && !found_r)
    else $error("state not cleared by reset");

endmodule
